FILE: rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// Shared widths and status types for the GCD / LCM unit and its divider.
// ----------------------------------------------------------------------------
package glu_pkg;

    // Fixed port widths of the operand and result fields
    localparam int FIELD_W    = 31;
    localparam int DIVISOR_W  = 31;
    localparam int MULTIPLE_W = 62;

    // Status returned by the shared divider
    typedef struct packed {
        logic busy;   // a division is in progress
        logic done;   // quotient and remainder are valid this cycle
    } t_div_stat;

endpackage

FILE: rtl/glu_divider.sv
// ----------------------------------------------------------------------------
// glu_divider
// Restoring radix-2 divider: one quotient bit per cycle, shared by the
// Euclid remainder steps and the final LCM quotient.
// ----------------------------------------------------------------------------
module glu_divider
    import glu_pkg::*;
#(
    parameter int WIDTH = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH+1:0] w_diff;
    logic             w_ge;
    logic             w_done;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_diff[WIDTH+1];
    assign w_done  = r_busy && (r_cnt == '0);

    // Control: load on start, count down one step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(WIDTH);
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    // Datapath: keep or restore the partial remainder, shift in quotient bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy && !w_done) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = w_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

    // A started division is in progress on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider not busy after start");

    // The remainder is always below the divisor when results are shown
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

    // The sequencer never hands over a zero divisor
    a_dvs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_dvs != '0))
        else $error("division by zero in progress");

endmodule

FILE: rtl/gcd_lcm_unit_top.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit_top
// GCD by Euclid's remainder iteration and LCM as (larger / GCD) * smaller,
// all divisions on one shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+------------------------
//  operands | i_start, o_busy, i_first_value,        | i_start && !o_busy
//           | i_second_value                         |
//  result   | o_valid, o_divisor, o_multiple         | o_valid, one cycle
//
//  An item with k Euclid remainder steps shows its result once those k divisions
//  and the final LCM quotient division on the shared divider are done; an item
//  whose smaller operand is zero returns on the next cycle.
//  The result strobe comes in the cycle after the last division finishes.
//  Reset is synchronous and active low; nothing is held between items.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_top
    import glu_pkg::*;
#(
    parameter int OPERAND_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [FIELD_W-1:0]    i_first_value,
    input  logic [FIELD_W-1:0]    i_second_value,
    output logic                  o_valid,
    output logic [DIVISOR_W-1:0]  o_divisor,
    output logic [MULTIPLE_W-1:0] o_multiple
);

    localparam int N = OPERAND_BITS;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EUCLID = 2'd1;
    localparam logic [1:0] S_QUOT   = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [N-1:0]   r_hi, n_hi;
    logic [N-1:0]   r_lo, n_lo;
    logic [N-1:0]   r_y, n_y;
    logic [N-1:0]   r_g, n_g;
    logic [2*N-1:0] r_prod, n_prod;
    logic           r_valid, n_valid;

    logic [N-1:0]   w_a, w_b, w_big, w_small;
    logic           w_accept;
    logic           w_div_start;
    logic [N-1:0]   w_div_dividend, w_div_divisor;
    t_div_stat      w_div_stat;
    logic [N-1:0]   w_quo, w_rem;
    logic [2*N-1:0] w_prod;

    // Order the masked operands, larger first
    assign w_a      = i_first_value[N-1:0];
    assign w_b      = i_second_value[N-1:0];
    assign w_big    = (w_a < w_b) ? w_b : w_a;
    assign w_small  = (w_a < w_b) ? w_a : w_b;
    assign w_accept = i_start && (r_state == S_IDLE);

    // LCM product of the final quotient and the smaller operand
    assign w_prod = (2*N)'(w_quo) * (2*N)'(r_lo);

    // Sequencer: issue divisions and collect results
    always_comb begin
        n_state        = r_state;
        n_hi           = r_hi;
        n_lo           = r_lo;
        n_y            = r_y;
        n_g            = r_g;
        n_prod         = r_prod;
        n_valid        = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = r_hi;
        w_div_divisor  = r_y;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_hi = w_big;
                    n_lo = w_small;
                    n_y  = w_small;
                    if (w_small == '0) begin
                        n_g     = w_big;
                        n_prod  = '0;
                        n_valid = 1'b1;
                    end else begin
                        w_div_start    = 1'b1;
                        w_div_dividend = w_big;
                        w_div_divisor  = w_small;
                        n_state        = S_EUCLID;
                    end
                end
            end
            S_EUCLID: begin
                if (w_div_stat.done) begin
                    w_div_start = 1'b1;
                    if (w_rem == '0) begin
                        // Last divisor is the GCD; divide the larger by it
                        n_g            = r_y;
                        w_div_dividend = r_hi;
                        w_div_divisor  = r_y;
                        n_state        = S_QUOT;
                    end else begin
                        // Advance the pair to (y, x mod y)
                        w_div_dividend = r_y;
                        w_div_divisor  = w_rem;
                        n_y            = w_rem;
                    end
                end
            end
            S_QUOT: begin
                if (w_div_stat.done) begin
                    n_prod  = w_prod;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_y    <= n_y;
        r_g    <= n_g;
        r_prod <= n_prod;
    end

    glu_divider #(
        .WIDTH       (N)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_divisor  = DIVISOR_W'(r_g);
    assign o_multiple = MULTIPLE_W'(r_prod);

    // Every accepted item is either in progress or answered next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_busy || o_valid))
        else $error("accepted item neither in progress nor answered");

    // The result strobe is shown only once the sequencer is back in idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while still busy");

    // A nonzero LCM always comes with a nonzero GCD
    a_lcm_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_multiple != '0)) |-> (o_divisor != '0))
        else $error("nonzero multiple with zero divisor");

    // The divider is idle whenever the sequencer is idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_stat.busy)
        else $error("divider running while sequencer idle");

endmodule
